@@ design/row_lru_tracker_defines.svh @@
// ---------------------------------------------------------------------------
// row_lru_tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROW_LRU_TRACKER_DEFINES_SVH
`define ROW_LRU_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define RLT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row_lru_tracker: same-cycle check failed");

// Next-cycle implication.
`define RLT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row_lru_tracker: next-cycle check failed");

`endif

@@ design/rlt_pkg.sv @@
// ---------------------------------------------------------------------------
// rlt_pkg
// Types, widths and defaults shared by the row LRU tracker modules.
// ---------------------------------------------------------------------------
package rlt_pkg;

    localparam int RLT_ENTRIES   = 16;
    localparam int RLT_ADDR_BITS = 32;

    // Fixed port field widths.
    localparam int ROW_ADDR_W = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int OCC_OUT_W  = 5;
    localparam int MAX_W      = 5;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } rlt_state_t;

    typedef struct packed {
        logic capture;  // register the incoming address
        logic lookup;   // register compare and victim results
        logic update;   // commit table changes and load the output word
    } rlt_cmd_t;

endpackage

@@ design/rlt_ctrl.sv @@
// ---------------------------------------------------------------------------
// rlt_ctrl
// Controller: sequences capture, lookup and update, and owns both handshakes.
// ---------------------------------------------------------------------------
`include "row_lru_tracker_defines.svh"

module rlt_ctrl
    import rlt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output rlt_cmd_t  cmd
);

    rlt_state_t state_reg;
    rlt_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load_ok;
    logic       accept;

    // The output register can take a new word when empty or being drained.
    assign load_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        accept      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Hold the finished lookup until the output register frees up.
                if (load_ok)
                begin
                    cmd.update = 1'b1;
                    in_stall   = 1'b0;
                    accept     = in_valid;
                    state_next = in_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.capture = accept;

        out_valid_next = out_valid_reg;
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `RLT_ASSERT_NXT(a_accept_then_lookup, in_valid && !in_stall, state_reg == ST_LOOKUP)
    `RLT_ASSERT_IMP(a_no_overwrite, cmd.update, !(out_valid_reg && out_stall))
    `RLT_ASSERT_NXT(a_update_shows_word, cmd.update, out_valid_reg)

endmodule

@@ design/rlt_datapath.sv @@
// ---------------------------------------------------------------------------
// rlt_datapath
// Tag store, recency ranks, occupancy and the output word register.
// ---------------------------------------------------------------------------
`include "row_lru_tracker_defines.svh"

module rlt_datapath
    import rlt_pkg::*;
#(
    parameter int ENTRIES   = RLT_ENTRIES,
    parameter int ADDR_BITS = RLT_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rlt_cmd_t              cmd,
    input  logic                  cfg_valid,
    input  logic [MAX_W-1:0]      cfg_data,
    input  logic [ROW_ADDR_W-1:0] row_address,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic [OCC_OUT_W-1:0]  occupancy
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    logic [ADDR_BITS-1:0] addr_in;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] tag_reg [ENTRIES];
    logic [SLOT_W-1:0]    rank_reg [ENTRIES];
    logic [CNT_W-1:0]     used_reg;
    logic [MAX_W-1:0]     max_reg;

    logic                 lk_hit_reg;
    logic                 lk_insert_reg;
    logic [SLOT_W-1:0]    lk_slot_reg;
    logic [CNT_W-1:0]     lk_ref_reg;

    logic                 out_hit_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [CNT_W-1:0]     out_occ_reg;

    logic [ENTRIES-1:0]   occ_vec;
    logic [ENTRIES-1:0]   match_vec;
    logic [ENTRIES-1:0]   victim_vec;
    logic                 any_match;
    logic [SLOT_W-1:0]    hit_idx;
    logic [SLOT_W-1:0]    victim_idx;
    logic [CNT_W-1:0]     hit_rank;
    logic [CMP_W-1:0]     max_ext;
    logic [CMP_W-1:0]     limit;
    logic                 insert;
    logic [SLOT_W-1:0]    slot_lk;
    logic [CNT_W-1:0]     ref_lk;
    logic [CNT_W-1:0]     used_next;

    // The compare uses the low ADDR_BITS address bits, zero-extending if wider.
    if (ADDR_BITS <= ROW_ADDR_W)
    begin : g_addr_trunc
        assign addr_in = row_address[ADDR_BITS-1:0];
    end
    else
    begin : g_addr_ext
        assign addr_in = {{(ADDR_BITS-ROW_ADDR_W){1'b0}}, row_address};
    end

    always_comb
    begin
        any_match  = 1'b0;
        hit_idx    = '0;
        victim_idx = '0;
        hit_rank   = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            occ_vec[k]    = CNT_W'(k) < used_reg;
            match_vec[k]  = occ_vec[k] && (tag_reg[k] == addr_reg);
            // Ranks of occupied slots are a permutation, so the oldest is
            // the one whose rank equals the occupancy minus one.
            victim_vec[k] = occ_vec[k] && (CNT_W'(rank_reg[k]) == used_reg - 1'b1);
        end
        // Walk downward so the lowest matching slot wins.
        for (int k = ENTRIES - 1; k >= 0; k--)
        begin
            if (match_vec[k])
            begin
                any_match = 1'b1;
                hit_idx   = SLOT_W'(k);
                hit_rank  = CNT_W'(rank_reg[k]);
            end
            if (victim_vec[k])
            begin
                victim_idx = SLOT_W'(k);
            end
        end

        max_ext = CMP_W'(max_reg);
        if (max_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (max_ext > CMP_W'(ENTRIES))
        begin
            limit = CMP_W'(ENTRIES);
        end
        else
        begin
            limit = max_ext;
        end
        insert = !any_match && (CMP_W'(used_reg) < limit);

        // An insert ages every occupied slot, so its reference rank is the count.
        if (any_match)
        begin
            slot_lk = hit_idx;
            ref_lk  = hit_rank;
        end
        else if (insert)
        begin
            slot_lk = used_reg[SLOT_W-1:0];
            ref_lk  = used_reg;
        end
        else
        begin
            slot_lk = victim_idx;
            ref_lk  = used_reg - 1'b1;
        end

        used_next = lk_insert_reg ? used_reg + 1'b1 : used_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= addr_in;
        end
        if (cmd.lookup)
        begin
            lk_hit_reg    <= any_match;
            lk_insert_reg <= insert;
            lk_slot_reg   <= slot_lk;
            lk_ref_reg    <= ref_lk;
        end
        if (cmd.update)
        begin
            if (!lk_hit_reg)
            begin
                tag_reg[lk_slot_reg] <= addr_reg;
            end
            out_hit_reg  <= lk_hit_reg;
            out_slot_reg <= lk_slot_reg;
            out_occ_reg  <= used_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            max_reg  <= MAX_ENTRIES_RESET;
            for (int k = 0; k < ENTRIES; k++)
            begin
                rank_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                used_reg <= used_next;
                for (int k = 0; k < ENTRIES; k++)
                begin
                    if (SLOT_W'(k) == lk_slot_reg)
                    begin
                        rank_reg[k] <= '0;
                    end
                    else if (occ_vec[k] && (CNT_W'(rank_reg[k]) < lk_ref_reg))
                    begin
                        rank_reg[k] <= rank_reg[k] + 1'b1;
                    end
                end
            end
        end
    end

    assign hit = out_hit_reg;

    if (SLOT_W >= SLOT_OUT_W)
    begin : g_slot_trunc
        assign slot = out_slot_reg[SLOT_OUT_W-1:0];
    end
    else
    begin : g_slot_ext
        assign slot = {{(SLOT_OUT_W-SLOT_W){1'b0}}, out_slot_reg};
    end

    if (CNT_W >= OCC_OUT_W)
    begin : g_occ_trunc
        assign occupancy = out_occ_reg[OCC_OUT_W-1:0];
    end
    else
    begin : g_occ_ext
        assign occupancy = {{(OCC_OUT_W-CNT_W){1'b0}}, out_occ_reg};
    end

    `RLT_ASSERT_NXT(a_used_steps_by_one, 1'b1,
        used_reg == $past(used_reg) || used_reg == $past(used_reg) + 1'b1)
    `RLT_ASSERT_IMP(a_hit_slot_occupied, cmd.update && lk_hit_reg,
        CNT_W'(lk_slot_reg) < used_reg)
    `RLT_ASSERT_IMP(a_used_in_range, cmd.lookup, CNT_W'(ENTRIES) >= used_reg)

endmodule

@@ design/row_lru_tracker.sv @@
// ---------------------------------------------------------------------------
// row_lru_tracker
// Fully associative LRU table of row addresses with hit, slot and occupancy.
// ---------------------------------------------------------------------------
// Each accepted address word passes through a lookup state and an update
// state. The lookup compares it against every occupied tag in parallel and
// picks the slot (hit, next free slot, or the oldest entry); the update
// rewrites the recency ranks and tag and loads the output register. A new
// word is taken while the previous one is committed; a stalled output
// whose register is still full holds the update until it drains. There is
// no clearing pass after reset. The max_entries register (reset 16, 0 acts
// as 1, values above ENTRIES act as ENTRIES) should be written while idle.
module row_lru_tracker
    import rlt_pkg::*;
#(
    parameter int ENTRIES   = RLT_ENTRIES,
    parameter int ADDR_BITS = RLT_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MAX_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ROW_ADDR_W-1:0] row_address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic [OCC_OUT_W-1:0]  occupancy
);

    rlt_cmd_t cmd;

    assign cfg_ready = 1'b1;

    rlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    rlt_datapath #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .row_address (row_address),
        .hit         (hit),
        .slot        (slot),
        .occupancy   (occupancy)
    );

endmodule
